// ===== rtl/core/caller_id_frame_detector_defines.svh =====
// Assertion macros shared by the caller id frame detector RTL.
// Stand-alone header: no other file is needed to use it.
`ifndef CALLER_ID_FRAME_DETECTOR_DEFINES_SVH
`define CALLER_ID_FRAME_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define CIDFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define CIDFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cidfd_pkg.sv =====
// Package for the caller id frame detector: types, character codes, offsets.
// No dependencies; imported by the window, the detector and the event interface.
`default_nettype none

package cidfd_pkg;

  localparam int WinDepth = 46;

  // Count of bytes since the last match, saturating at one frame length
  localparam logic [5:0] FrameCount = 6'd47;
  localparam logic [5:0] ShortCount = 6'd3;

  // Offsets inside the 47-byte frame (offset 46 is the byte just received)
  localparam int OffShortLetter = 44;
  localparam int OffCr          = 45;
  localparam int OffMark        = 22;
  localparam int OffSelect      = 38;
  localparam int OffCallHigh    = 10;
  localparam int OffCallLow     = 16;
  localparam int CallBytes      = 6;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChE  = 8'h45;
  localparam logic [7:0] ChF  = 8'h46;
  localparam logic [7:0] ChI  = 8'h49;
  localparam logic [7:0] ChA  = 8'h41;
  localparam logic [7:0] ChD  = 8'h44;
  localparam logic [7:0] ChO  = 8'h4F;

  typedef enum logic [2:0] {
    EV_SHORT   = 3'd0,
    EV_DETECT  = 3'd1,
    EV_CALLER  = 3'd2,
    EV_HANGUP  = 3'd3,
    EV_OFFHOOK = 3'd4
  } event_kind_t;

  // Window of the last bytes, entry 0 oldest
  typedef logic [WinDepth-1:0][7:0] window_t;

  // Control from the decoder to the window
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

  function automatic logic is_reply_letter(input logic [7:0] c);
    return (c == ChF) || (c == ChI) || (c == ChA) || (c == ChD) || (c == ChO);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cidfd_ifs.sv =====
// Valid/ready channels of the caller id frame detector: received bytes and events.
// Depends on cidfd_pkg for the event kind type.
`default_nettype none

interface cidfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cidfd_ev_if
  import cidfd_pkg::*;
;
  logic        valid;
  logic        ready;
  event_kind_t event_kind;
  logic [7:0]  reply_letter;
  logic [47:0] caller_high;
  logic [47:0] caller_low;

  modport source (output valid, output event_kind, output reply_letter,
                  output caller_high, output caller_low, input ready);
  modport sink (input valid, input event_kind, input reply_letter,
                input caller_high, input caller_low, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cidfd_window.sv =====
// Shift line of the last 46 received bytes and the count of bytes since a match.
// Depends on cidfd_pkg.
`default_nettype none

module cidfd_window
  import cidfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire win_ctl_t   ctl,
  input  wire logic [7:0] new_byte,
  output window_t         win,
  output logic [5:0]      fill_count,
  output logic [5:0]      seen_count
);

  window_t    window;
  logic [5:0] count;
  logic [5:0] count_next;

  // Count including the byte now being judged, saturating at one frame
  assign seen_count = (count >= FrameCount) ? FrameCount : count + 6'd1;

  always_comb begin
    count_next = count;
    if (ctl.shift) begin
      count_next = ctl.clear ? 6'd0 : seen_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 6'd0;
    end else begin
      count <= count_next;
    end
  end

  // Advance the shift line: drop the oldest, append the new byte
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      window <= {new_byte, window[WinDepth-1:1]};
    end
  end

  assign win        = window;
  assign fill_count = count;

endmodule

`default_nettype wire

// ===== rtl/core/caller_id_frame_detector.sv =====
// An event passes the input register, then the result register, after its byte
// is accepted. Throughput: one byte per cycle, but a byte that yields an event
// waits while the result register is full and not taken; the window is compared
// with the fixed frame pattern combinationally. rst (synchronous) clears the
// count, test mode and both valid flags; the byte window holds no reset value.
`default_nettype none
`include "caller_id_frame_detector_defines.svh"

module caller_id_frame_detector
  import cidfd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_wr_en,
  input  wire logic   cfg_wr_data,
  cidfd_rx_if.sink    rx_ch,
  cidfd_ev_if.source  ev_ch
);

  logic        test_mode;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_fire;
  win_ctl_t    win_ctl;
  window_t     win;
  logic [5:0]  fill_count;
  logic [5:0]  seen_count;

  logic        frame_hit;
  logic        short_hit;
  logic        emit;
  event_kind_t kind;
  logic [7:0]  letter;
  logic [47:0] call_hi;
  logic [47:0] call_lo;

  logic        ev_valid;
  event_kind_t ev_kind;
  logic [7:0]  ev_letter;
  logic [47:0] ev_hi;
  logic [47:0] ev_lo;
  logic        out_free;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      test_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      test_mode <= cfg_wr_data;
    end
  end

  cidfd_window u_window (
    .clk        (clk),
    .rst        (rst),
    .ctl        (win_ctl),
    .new_byte   (s1_byte),
    .win        (win),
    .fill_count (fill_count),
    .seen_count (seen_count)
  );

  // Match the window plus the held byte against both reply patterns
  always_comb begin
    frame_hit = (seen_count >= FrameCount) && !is_reply_letter(win[0]) &&
                (win[OffMark] == ChE) && (win[OffCr] == ChCr) && (s1_byte == ChLf);
    short_hit = (seen_count >= ShortCount) && is_reply_letter(win[OffShortLetter]) &&
                (win[OffCr] == ChCr) && (s1_byte == ChLf);
    emit    = 1'b0;
    kind    = EV_SHORT;
    letter  = win[OffShortLetter];
    call_hi = '0;
    call_lo = '0;
    if (frame_hit) begin
      letter = win[0];
      if (test_mode) begin
        emit = 1'b1;
        kind = EV_DETECT;
      end else if (win[OffSelect] == ChI) begin
        emit = 1'b1;
        kind = EV_CALLER;
        for (int i = 0; i < CallBytes; i++) begin
          call_hi[47-8*i -: 8] = win[OffCallHigh+i];
          call_lo[47-8*i -: 8] = win[OffCallLow+i];
        end
      end else if (win[OffSelect] == ChD) begin
        emit = 1'b1;
        kind = EV_HANGUP;
      end else if (win[OffSelect] == ChA) begin
        emit = 1'b1;
        kind = EV_OFFHOOK;
      end
    end else if (short_hit) begin
      emit = 1'b1;
    end
  end

  // Hold the judged byte while a result cannot be stored
  assign out_free      = !ev_valid || ev_ch.ready;
  assign s1_fire       = s1_valid && (!emit || out_free);
  assign rx_ch.ready   = !s1_valid || s1_fire;
  assign win_ctl.shift = s1_fire;
  assign win_ctl.clear = frame_hit || short_hit;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_ch.ready) begin
      s1_valid <= rx_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ch.valid && rx_ch.ready) begin
      s1_byte <= rx_ch.rx_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      ev_valid <= 1'b1;
    end else if (ev_ch.ready) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      ev_kind   <= kind;
      ev_letter <= letter;
      ev_hi     <= call_hi;
      ev_lo     <= call_lo;
    end
  end

  assign ev_ch.valid        = ev_valid;
  assign ev_ch.event_kind   = ev_kind;
  assign ev_ch.reply_letter = ev_letter;
  assign ev_ch.caller_high  = ev_hi;
  assign ev_ch.caller_low   = ev_lo;

  `CIDFD_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, fill_count <= FrameCount,
    "fill count beyond frame length")
  `CIDFD_ASSERT_NEXT(a_match_clears, clk, rst, s1_fire && (frame_hit || short_hit),
    fill_count == 6'd0, "count not cleared after a match")
  `CIDFD_ASSERT_SAME(a_caller_zero, clk, rst, ev_valid && (ev_kind != EV_CALLER),
    (ev_hi == '0) && (ev_lo == '0), "caller fields set on a non caller event")
  `CIDFD_ASSERT_NEXT(a_result_kept, clk, rst, ev_valid && !ev_ch.ready,
    ev_valid, "pending result dropped")

endmodule

`default_nettype wire
